// ----- src/sgb_pkg.sv -----
// shared types and constants for the spatial grid binning block
package sgb_pkg;
    localparam int          TABLE_ENTRIES = 64;
    localparam int          LIST_CAPACITY = 16;
    localparam int          MAX_SPAN      = 4;
    localparam logic [15:0] PENALTY  = 16'hFFFF;
    localparam int          TOT_W    = 47;
    localparam logic [0:0]  FUNC_CLR = 1'b0;
    localparam logic [1:0]  ST_OK    = 2'd0;
    localparam logic [1:0]  ST_TFULL = 2'd1;
    localparam logic [1:0]  ST_LFULL = 2'd2;

    typedef struct packed {
        logic        func;
        logic [15:0] object_id;
        logic signed [31:0] box_left;
        logic signed [31:0] box_bottom;
        logic signed [31:0] box_right;
        logic signed [31:0] box_top;
        logic signed [31:0] motion_sum;
        logic [15:0] object_age;
        logic [7:0]  collide_layer;
        logic        no_optimize;
    } t_in;

    typedef struct packed {
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic [5:0]  entry_index;
        logic [3:0]  slot_index;
        logic [46:0] motion_total;
        logic [1:0]  status;
        logic        span_clamped;
        logic        last;
    } t_out;

    // search request handed down the cell chain
    typedef struct packed {
        logic        vld;
        logic        hit;
        logic [15:0] kx;
        logic [15:0] ky;
        logic [7:0]  layer;
    } t_probe;
endpackage

// ----- src/sgb_div.sv -----
// restoring divider producing a floored, saturated 16-bit cell coordinate
module sgb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic signed [31:0] i_num,
    input  logic [30:0] i_den,
    output logic        o_done,
    output logic signed [15:0] o_q
);
    logic [5:0]  r_cnt;
    logic        r_run, r_neg;
    logic [31:0] r_quo, r_rem, n_rem;
    logic [32:0] trial;
    logic [32:0] adj;
    logic signed [33:0] qf;

    assign trial = {r_rem, r_quo[31]} - {2'b0, i_den};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; o_done <= 1'b0; r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1; r_cnt <= 6'd32; r_neg <= i_num[31];
                r_quo <= i_num[31] ? 32'(-i_num) : 32'(i_num);
                r_rem <= '0;
            end else if (r_run) begin
                if (!trial[32]) begin
                    r_rem <= trial[31:0]; r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[30:0], r_quo[31]}; r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_run <= 1'b0; o_done <= 1'b1;
                end
            end
        end
    end
    assign n_rem = r_rem;
    assign adj = {1'b0, r_quo} + 33'(r_neg && (n_rem != 0));
    assign qf = r_neg ? -$signed({1'b0, adj}) : $signed({1'b0, adj});
    assign o_q = (qf > 34'sd32767) ? 16'sh7FFF : (qf < -34'sd32768) ? 16'sh8000 : qf[15:0];
endmodule

// ----- src/sgb_cell.sv -----
// one table entry: key compare, member count and motion total
module sgb_cell (
    input  logic i_clk,
    input  logic i_rst_n,
    input  sgb_pkg::t_probe i_probe,
    input  logic i_wr,
    input  logic i_claim,
    input  logic [4:0]  i_cnt,
    input  logic [46:0] i_mot,
    output sgb_pkg::t_probe o_probe,
    output logic [4:0]  o_cnt,
    output logic [46:0] o_mot,
    output logic        o_match
);
    import sgb_pkg::*;
    logic [15:0] r_kx, r_ky;
    logic [7:0]  r_ly;
    logic [4:0]  r_cnt;
    logic [46:0] r_mot;
    assign o_match = i_probe.vld && !i_probe.hit && r_kx == i_probe.kx &&
                     r_ky == i_probe.ky && r_ly == i_probe.layer;
    assign o_cnt = r_cnt;
    assign o_mot = r_mot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_probe <= '0;
        else begin
            o_probe <= '{vld: i_probe.vld, hit: i_probe.hit | o_match, kx: i_probe.kx,
                         ky: i_probe.ky, layer: i_probe.layer};
        end
        if (i_claim) begin
            r_kx <= i_probe.kx; r_ky <= i_probe.ky; r_ly <= i_probe.layer;
        end
        if (i_wr) begin
            r_cnt <= i_cnt; r_mot <= i_mot;
        end
    end
endmodule

// ----- src/spatial_grid_binning.sv -----
// spatial grid binning top: config port, sequencer, divider and entry chain
// throughput: one item at a time; up to MAX_SPAN^2 cells, each one pass of the chain
// the entry chain search sets the per-cell cost; clear empties the table without leaving idle
// reset: synchronous active low, table empty, registers at defaults
// results appear one cycle each on o_res_vld, the receiver cannot stall
module spatial_grid_binning (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  sgb_pkg::t_in i_item,
    output logic o_res_vld,
    output sgb_pkg::t_out o_res,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sgb_pkg::*;
    localparam int EW = $clog2(TABLE_ENTRIES);
    localparam int MW = $clog2(MAX_SPAN + 1);
    localparam logic [3:0] A_SIZE = 4'd0, A_MOT = 4'd4, A_AGE = 4'd8;
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_PREP = 3'd2,
                           S_SRCH = 3'd3, S_UPD = 3'd4;

    logic [30:0] r_size;
    logic signed [31:0] r_mmot;
    logic [15:0] r_mage;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 31'd4194304; r_mmot <= 32'sd65536; r_mage <= 16'd10;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                A_SIZE:  r_size <= pwdata[30:0];
                A_MOT:   r_mmot <= pwdata;
                A_AGE:   r_mage <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr)
            A_SIZE:  prdata = {1'b0, r_size};
            A_MOT:   prdata = r_mmot;
            A_AGE:   prdata = {16'b0, r_mage};
            default: prdata = '0;
        endcase
    end

    logic [2:0] r_st;
    t_in r_in;
    logic [1:0] r_dsel;
    logic dgo, ddone;
    logic signed [31:0] dnum;
    logic signed [15:0] dq;
    logic signed [15:0] r_x0, r_y0, r_x1, r_y1, r_cx, r_cy;
    logic [MW-1:0] r_ix, r_iy;
    logic r_clamp;
    logic [EW:0] r_used;
    logic [EW:0] r_scnt;
    logic r_found;
    logic [EW-1:0] r_fidx;
    logic signed [47:0] term;
    logic [MW-1:0] nx, ny;

    assign busy = (r_st != S_IDLE);
    always_comb begin
        unique case (r_dsel)
            2'd0: dnum = r_in.box_left;
            2'd1: dnum = r_in.box_bottom;
            2'd2: dnum = r_in.box_right;
            default: dnum = r_in.box_top;
        endcase
    end
    sgb_div u_div (.i_clk, .i_rst_n, .i_go(dgo), .i_num(dnum),
        .i_den(r_size == 0 ? 31'd1 : r_size), .o_done(ddone), .o_q(dq));

    t_probe chain [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] match, wr, claim;
    logic [4:0]  ccnt [TABLE_ENTRIES];
    logic [46:0] cmot [TABLE_ENTRIES];
    logic [4:0]  wcnt;
    logic [46:0] wmot;
    logic [EW-1:0] hidx;
    logic hit_any;

    assign chain[0] = '{vld: (r_st == S_PREP), hit: 1'b0, kx: r_cx, ky: r_cy,
                        layer: r_in.collide_layer};
    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            t_probe pin;
            always_comb begin
                pin = chain[g];
                if (EW'(g) >= r_used[EW-1:0] && !r_used[EW]) pin.vld = 1'b0;
            end
            sgb_cell u_cell (.i_clk, .i_rst_n, .i_probe(pin),
                .i_wr(wr[g]), .i_claim(claim[g]), .i_cnt(wcnt), .i_mot(wmot),
                .o_probe(chain[g+1]), .o_cnt(ccnt[g]), .o_mot(cmot[g]),
                .o_match(match[g]));
        end
    endgenerate
    // only one cell matches per cell step; remember which
    always_ff @(posedge i_clk) begin
        if (r_st == S_PREP) r_found <= |match;
        else if (|match) r_found <= 1'b1;
        for (int k = 0; k < TABLE_ENTRIES; k++) if (match[k]) r_fidx <= EW'(k);
    end
    assign hit_any = r_found;

    assign term = (r_in.no_optimize || ($signed(r_in.motion_sum) < r_mmot &&
                   r_in.object_age < r_mage)) ? 48'sh0000FFFF0000
                   : 48'(signed'(r_in.motion_sum));

    logic full, lfull;
    logic [EW-1:0] eidx;
    logic [4:0] cur_cnt;
    logic [46:0] cur_mot;
    logic signed [48:0] sum;
    logic [46:0] sat;
    assign full = !hit_any && r_used[EW];
    assign eidx = hit_any ? r_fidx : r_used[EW-1:0];
    assign cur_cnt = hit_any ? ccnt[eidx] : 5'd0;
    assign cur_mot = hit_any ? cmot[eidx] : 47'd0;
    assign lfull = 32'(cur_cnt) >= LIST_CAPACITY;
    assign sum = $signed({2'b0, cur_mot}) + 49'(term);
    assign sat = sum[48] ? 47'd0 : (sum[47] ? {47{1'b1}} : sum[46:0]);
    assign hidx = eidx;
    assign wcnt = cur_cnt + 5'd1;
    assign wmot = sat;
    always_comb begin
        wr = '0; claim = '0;
        if (r_st == S_UPD && !full && !lfull) wr[hidx] = 1'b1;
        if (r_st == S_UPD && !full && !hit_any) begin
            claim[hidx] = 1'b1; wr[hidx] = 1'b1;
        end
    end
    // claimed cell latches the key from its probe input; the latch does not look at the probe's valid bit
    assign nx = r_ix + MW'(1);
    assign ny = r_iy + MW'(1);

    logic signed [16:0] spx, spy;
    assign spx = 17'(r_x1) - 17'(r_x0);
    assign spy = 17'(dq) - 17'(r_y0);
    logic lastc;
    assign lastc = (r_cx == r_x1) && (r_cy == r_y1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_used <= '0; o_res_vld <= 1'b0; dgo <= 1'b0;
        end else begin
            o_res_vld <= (r_st == S_UPD);
            dgo <= (r_st == S_IDLE && start && i_item.func != FUNC_CLR) ||
                   (r_st == S_DIV && ddone && r_dsel != 2'd3);
            unique case (r_st)
                S_IDLE: if (start) begin
                    r_in <= i_item;
                    if (i_item.func == FUNC_CLR) r_used <= '0;
                    else begin
                        r_st <= S_DIV; r_dsel <= 2'd0;
                    end
                end
                S_DIV: if (ddone) begin
                    if (r_dsel == 2'd3) begin
                        r_clamp <= (spx >= 17'(MAX_SPAN)) || (spy >= 17'(MAX_SPAN));
                        r_ix <= '0; r_iy <= '0; r_cx <= r_x0; r_cy <= r_y0;
                        r_x1 <= (spx >= 17'(MAX_SPAN)) ? 16'(r_x0 + 16'(MAX_SPAN - 1)) : r_x1;
                        r_y1 <= (spy >= 17'(MAX_SPAN)) ? 16'(r_y0 + 16'(MAX_SPAN - 1)) : dq;
                        r_st <= (dq < r_y0 || r_x1 < r_x0) ? S_IDLE : S_PREP;
                    end else begin
                        unique case (r_dsel)
                            2'd0: r_x0 <= dq;
                            2'd1: r_y0 <= dq;
                            default: r_x1 <= dq;
                        endcase
                        r_dsel <= r_dsel + 2'd1;
                    end
                end
                S_PREP: begin r_st <= S_SRCH; r_scnt <= '0; end
                S_SRCH: begin
                    r_scnt <= r_scnt + (EW+1)'(1);
                    if (32'(r_scnt) == TABLE_ENTRIES + 1) r_st <= S_UPD;
                end
                default: begin
                    o_res.cell_x <= r_cx; o_res.cell_y <= r_cy;
                    o_res.span_clamped <= r_clamp; o_res.last <= lastc;
                    o_res.entry_index <= full ? 6'd0 : 6'(eidx);
                    o_res.slot_index <= (full || lfull) ? 4'd0 : 4'(cur_cnt);
                    o_res.motion_total <= full ? 47'd0 : (lfull ? cur_mot : sat);
                    o_res.status <= full ? ST_TFULL : (lfull ? ST_LFULL : ST_OK);
                    if (!full && !hit_any) r_used <= r_used + (EW+1)'(1);
                    if (lastc) r_st <= S_IDLE;
                    else begin
                        r_st <= S_PREP;
                        if (r_cy == r_y1) begin
                            r_cy <= r_y0; r_cx <= r_cx + 16'sd1; r_ix <= nx; r_iy <= '0;
                        end else begin
                            r_cy <= r_cy + 16'sd1; r_iy <= ny;
                        end
                    end
                end
            endcase
        end
    end
endmodule

// ----- tb/spatial_grid_binning_test.sv -----
// self-checking testbench for the spatial grid binning block with its own binning predictor
module spatial_grid_binning_test;
    import sgb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [0:0] FUNC_INS = 1'b1;
    localparam logic [3:0] REG_CELL_SIZE  = 4'd0;
    localparam logic [3:0] REG_MIN_MOTION = 4'd4;
    localparam logic [3:0] REG_MIN_AGE    = 4'd8;
    localparam longint TOTAL_CEIL   = 64'h7FFF_FFFF_FFFF;
    localparam longint PENALTY_Q16  = longint'(PENALTY) * 65536;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_item;
    logic        o_res_vld;
    t_out        o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spatial_grid_binning u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_res_vld(o_res_vld),
        .o_res    (o_res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor copy of registers and partition table
    logic [30:0]        cell_size_q;
    logic signed [31:0] min_motion_q;
    logic [15:0]        min_age_q;
    int                 used_entries;
    int                 key_x [TABLE_ENTRIES];
    int                 key_y [TABLE_ENTRIES];
    int                 key_layer [TABLE_ENTRIES];
    int                 member_count [TABLE_ENTRIES];
    longint             motion_acc [TABLE_ENTRIES];

    t_out expected_bins[$];
    int   errors;
    int   send_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int grid_coord(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q = q - 1;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    function automatic void bin_object(t_in it);
        longint d, term, total;
        int     x0, y0, x1, y1, cx, cy, e;
        bit     clamped, hit;
        t_out   r;
        if (it.func == FUNC_CLR) begin
            used_entries = 0;
            return;
        end
        d  = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
        x0 = grid_coord(longint'(it.box_left), d);
        y0 = grid_coord(longint'(it.box_bottom), d);
        x1 = grid_coord(longint'(it.box_right), d);
        y1 = grid_coord(longint'(it.box_top), d);
        if (x1 < x0 || y1 < y0) return;
        clamped = 0;
        if (x1 - x0 + 1 > MAX_SPAN) begin
            x1 = x0 + MAX_SPAN - 1;
            clamped = 1;
        end
        if (y1 - y0 + 1 > MAX_SPAN) begin
            y1 = y0 + MAX_SPAN - 1;
            clamped = 1;
        end
        term = longint'(it.motion_sum);
        if ((it.motion_sum < min_motion_q && it.object_age < min_age_q) || it.no_optimize)
            term = PENALTY_Q16;
        for (cx = x0; cx <= x1; cx++) begin
            for (cy = y0; cy <= y1; cy++) begin
                hit = 0;
                for (e = 0; e < used_entries; e++) begin
                    if (key_x[e] == cx && key_y[e] == cy && key_layer[e] == it.collide_layer) begin
                        hit = 1;
                        break;
                    end
                end
                if (!hit && used_entries < TABLE_ENTRIES) begin
                    e = used_entries;
                    used_entries++;
                    key_x[e] = cx;
                    key_y[e] = cy;
                    key_layer[e] = it.collide_layer;
                    member_count[e] = 0;
                    motion_acc[e] = 0;
                    hit = 1;
                end
                r = '0;
                r.cell_x = cx[15:0];
                r.cell_y = cy[15:0];
                r.span_clamped = clamped;
                r.last = (cx == x1 && cy == y1);
                if (!hit) begin
                    r.status = ST_TFULL;
                end else if (member_count[e] >= LIST_CAPACITY) begin
                    r.status = ST_LFULL;
                    r.entry_index = e[5:0];
                    r.motion_total = motion_acc[e][46:0];
                end else begin
                    r.status = ST_OK;
                    r.entry_index = e[5:0];
                    r.slot_index = member_count[e][3:0];
                    member_count[e]++;
                    total = motion_acc[e] + term;
                    if (total < 0) total = 0;
                    if (total > TOTAL_CEIL) total = TOTAL_CEIL;
                    motion_acc[e] = total;
                    r.motion_total = total[46:0];
                end
                expected_bins.push_back(r);
            end
        end
    endfunction

    task automatic field_check(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_res_vld) begin
            if (expected_bins.size() == 0) begin
                $display("%0t unexpected result expected none actual %h", $realtime, o_res);
                errors++;
            end else begin
                e = expected_bins.pop_front();
                field_check("cell_x", e.cell_x, o_res.cell_x);
                field_check("cell_y", e.cell_y, o_res.cell_y);
                field_check("entry_index", e.entry_index, o_res.entry_index);
                field_check("slot_index", e.slot_index, o_res.slot_index);
                field_check("motion_total", e.motion_total, o_res.motion_total);
                field_check("status", e.status, o_res.status);
                field_check("span_clamped", e.span_clamped, o_res.span_clamped);
                field_check("last", e.last, o_res.last);
            end
        end
    end

    task automatic reg_write(logic [3:0] addr, logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            REG_CELL_SIZE:  cell_size_q = data[30:0];
            REG_MIN_MOTION: min_motion_q = data;
            REG_MIN_AGE:    min_age_q = data[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic reg_readback(logic [3:0] addr, logic [31:0] mask, logic [31:0] exp_v);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        field_check("register", exp_v & mask, prdata & mask);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] cs, logic [31:0] mm, logic [31:0] ma);
        reg_write(REG_CELL_SIZE, cs);
        reg_write(REG_MIN_MOTION, mm);
        reg_write(REG_MIN_AGE, ma);
        reg_readback(REG_CELL_SIZE, 32'h7FFF_FFFF, cs);
        reg_readback(REG_MIN_MOTION, 32'hFFFF_FFFF, mm);
        reg_readback(REG_MIN_AGE, 32'h0000_FFFF, ma);
    endtask

    task automatic send_item(t_in it);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        bin_object(it);
        if ($urandom_range(1, 100) <= send_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        int guard;
        start <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while ((expected_bins.size() != 0 || busy) && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    function automatic t_in insert_box(longint l, longint b, longint r, longint t,
                                       logic [15:0] id, logic [7:0] layer);
        t_in it;
        it = '0;
        it.func = FUNC_INS;
        it.object_id = id;
        it.box_left = l[31:0];
        it.box_bottom = b[31:0];
        it.box_right = r[31:0];
        it.box_top = t[31:0];
        it.motion_sum = 32'sd131072;
        it.object_age = 16'd100;
        it.collide_layer = layer;
        return it;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_in random_item();
        t_in    it;
        longint cs, l, b;
        int     sx, sy;
        if ($urandom_range(1, 100) <= 25) begin
            it = t_in'({$urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom});
            if ($urandom_range(1, 100) <= 80) it.func = FUNC_INS;
            return it;
        end
        cs = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
        l = (longint'($urandom_range(0, 6)) - 3) * cs + longint'($urandom_range(0, 255));
        b = (longint'($urandom_range(0, 6)) - 3) * cs + longint'($urandom_range(0, 255));
        sx = ($urandom_range(1, 100) <= 10) ? $urandom_range(4, 6) : $urandom_range(0, 2);
        sy = ($urandom_range(1, 100) <= 10) ? $urandom_range(4, 6) : $urandom_range(0, 2);
        it = insert_box(clip32(l), clip32(b), clip32(l + sx * cs), clip32(b + sy * cs),
                        16'($urandom), 8'($urandom_range(0, 2)));
        if ($urandom_range(1, 100) <= 6) it.func = FUNC_CLR;
        it.motion_sum = $urandom_range(0, 1) ? 32'($urandom_range(0, 400000)) - 32'sd200000
                                             : $urandom;
        it.object_age = $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom);
        it.no_optimize = ($urandom_range(1, 100) <= 15);
        return it;
    endfunction

    task automatic test_member_list_overflow();
        t_in it;
        send_item(insert_box(0, 0, 0, 0, 16'h0000, 8'h00));
        it = insert_box(0, 0, 0, 0, 16'h0000, 8'h00);
        it.func = FUNC_CLR;
        send_item(it);
        for (int k = 0; k < LIST_CAPACITY + 1; k++) begin
            it = insert_box(k, k, 65535, 65535, 16'(k * 4099), 8'h00);
            it.motion_sum = (k % 3 == 0) ? -32'sd2147483648 :
                            (k % 3 == 1) ? 32'sd2147483647 : 32'sd100;
            it.object_age = (k % 4 == 0) ? 16'd0 : 16'hFFFF;
            it.no_optimize = (k % 5 == 2);
            if (k == LIST_CAPACITY) it.object_id = 16'hFFFF;
            send_item(it);
        end
        wait_idle();
    endtask

    task automatic test_extreme_boxes();
        t_in it;
        it = insert_box(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647,
                        16'hFFFF, 8'hFF);
        it.motion_sum = 32'sd2147483647;
        send_item(it);
        it = insert_box(64'sd2147483647, 0, -64'sd2147483648, 0, 16'h1234, 8'h01);
        send_item(it);
        wait_idle();
    endtask

    task automatic test_table_overflow();
        t_in    it;
        longint span;
        span = 4 * longint'(cell_size_q);
        it = insert_box(0, 0, 0, 0, 16'h0, 8'h0);
        it.func = FUNC_CLR;
        send_item(it);
        for (int k = 0; k < 5; k++)
            send_item(insert_box(k * span, 0, k * span + span - 1, span - 1, 16'(k), 8'h07));
        wait_idle();
    endtask

    task automatic test_random_phase(int count, int idle_pct);
        send_idle_pct = idle_pct;
        for (int k = 0; k < count; k++) send_item(random_item());
        wait_idle();
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cell_size_q = 31'd4194304;
        min_motion_q = 32'sd65536;
        min_age_q = 16'd10;
        used_entries = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (300) @(posedge i_clk);

        test_member_list_overflow();
        test_extreme_boxes();
        test_table_overflow();
        test_random_phase(60, 0);

        configure(32'h0001_0000, 32'h8000_0000, 32'h0000_FFFF);
        test_random_phase(60, 76);

        configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
        test_random_phase(40, 36);

        configure(32'h0000_0000, 32'h0000_0000, 32'h0000_0008);
        test_extreme_boxes();
        test_random_phase(40, 76);

        configure(32'h0000_0100, 32'hFFFF_0000, 32'h0000_0010);
        test_random_phase(50, 36);

        if (expected_bins.size() != 0) begin
            $display("%0t missing results expected %0d actual 0", $realtime,
                     expected_bins.size());
            errors++;
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
